FILE: hdl/generational_slot_allocator_macros.svh
// Assertion macros for the generational slot allocator checker.
// Depends on nothing; included by the files that carry assertions.
`ifndef GENERATIONAL_SLOT_ALLOCATOR_MACROS_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_MACROS_SVH

// Overlapping implication, sampled on the rising clock edge, off during reset.
`define GSA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define GSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/gsa_pkg.sv
// Shared widths, request kinds and status codes of the generational slot allocator.
// Depends on nothing; imported by every module of the block.
package gsa_pkg;

    localparam int POOL_SLOTS_DEF = 1024;

    localparam int KIND_W   = 2;
    localparam int IDX_W    = 10;
    localparam int GEN_W    = 32;
    localparam int STATUS_W = 2;
    localparam int ARITH_W  = 32;

    localparam logic [KIND_W-1:0] KIND_ALLOC    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_VALIDATE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd2;

endpackage

FILE: hdl/gsa_gen_table.sv
// Generation table: one 32-bit generation per slot, registered read.
// Depends on gsa_pkg; a write and a read of the same address in one cycle is forwarded.
module gsa_gen_table
    import gsa_pkg::*;
#(
    parameter int POOL_SLOTS = POOL_SLOTS_DEF,
    localparam int SLOT_W = $clog2(POOL_SLOTS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SLOT_W-1:0] i_rd_addr,
    input  logic              i_we,
    input  logic [SLOT_W-1:0] i_wr_addr,
    input  logic [GEN_W-1:0]  i_wr_data,
    output logic [GEN_W-1:0]  o_rd_data
);

    logic [GEN_W-1:0] r_mem [POOL_SLOTS];
    logic [GEN_W-1:0] r_q;
    logic [GEN_W-1:0] r_fwd_data;
    logic             r_fwd_hit;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_q        <= r_mem[i_rd_addr];
        r_fwd_data <= i_wr_data;
    end

    // The array read returns the old word when the same edge writes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else begin
            r_fwd_hit <= i_we && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_fwd_hit ? r_fwd_data : r_q;

endmodule

FILE: hdl/gsa_free_stack.sv
// LIFO stack of freed slot indexes with a cached top and a prefetched second entry.
// Depends on gsa_pkg; push and pop are never asked in the same cycle.
module gsa_free_stack
    import gsa_pkg::*;
#(
    parameter int POOL_SLOTS = POOL_SLOTS_DEF,
    localparam int SLOT_W = $clog2(POOL_SLOTS),
    localparam int CNT_W  = $clog2(POOL_SLOTS + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_pop,
    input  logic [SLOT_W-1:0] i_push_slot,
    output logic [CNT_W-1:0]  o_count,
    output logic [CNT_W-1:0]  o_next_count,
    output logic [SLOT_W-1:0] o_next_top
);

    logic [SLOT_W-1:0] r_mem [POOL_SLOTS];
    logic [CNT_W-1:0]  r_count;
    logic [SLOT_W-1:0] r_top;
    logic [SLOT_W-1:0] r_below;
    logic [CNT_W-1:0]  n_count;
    logic [SLOT_W-1:0] n_top;
    logic [CNT_W-1:0]  w_below_cnt;

    always_comb begin
        n_count = r_count;
        n_top   = r_top;
        if (i_push) begin
            n_count = r_count + CNT_W'(1);
            n_top   = i_push_slot;
        end else if (i_pop) begin
            n_count = r_count - CNT_W'(1);
            n_top   = r_below;
        end
    end

    // The entry under the new top is fetched every cycle, so a pop is ready next cycle.
    assign w_below_cnt = n_count - CNT_W'(2);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_count[SLOT_W-1:0]] <= i_push_slot;
        end
        r_below <= r_mem[w_below_cnt[SLOT_W-1:0]];
        r_top   <= n_top;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_count      = r_count;
    assign o_next_count = n_count;
    assign o_next_top   = n_top;

endmodule

FILE: hdl/generational_slot_allocator.sv
// Top level of the generational slot allocator: request register, decision logic, result register.
// Depends on gsa_pkg, gsa_gen_table and gsa_free_stack.
//
//  Channel   Handshake           Payload
//  --------  ------------------  ------------------------------------------------------
//  request   start, busy         i_kind, i_slot_index, i_handle_generation
//  result    o_done (strobe)     o_status, o_out_index, o_out_generation, o_handle_ok
//
// One request is taken in every cycle; busy stays low. A request transferred at a rising
// edge passes through the request register and the result register, and its result then
// shows on the result ports for a single cycle, marked by o_done, and transfers at the edge
// that ends that cycle. The pace is set by the registered read of the generation table:
// the read is issued in the transfer cycle, the decision and the write-back happen in the
// next one, and the result register follows.
// Reset is synchronous and active low. It clears the free count and the used-slot count;
// no clearing pass runs over the tables, because the stored generation of a slot at or above
// the used-slot count is never used and a slot taken fresh is known to have generation zero.
// The receiver cannot stall the result; each result is a transfer in its one cycle.
module generational_slot_allocator
    import gsa_pkg::*;
#(
    parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [IDX_W-1:0]    i_slot_index,
    input  logic [GEN_W-1:0]    i_handle_generation,
    output logic                o_done,
    output logic [STATUS_W-1:0] o_status,
    output logic [IDX_W-1:0]    o_out_index,
    output logic [GEN_W-1:0]    o_out_generation,
    output logic                o_handle_ok
);

    localparam int SLOT_W = $clog2(POOL_SLOTS);
    localparam int CNT_W  = $clog2(POOL_SLOTS + 1);
    localparam logic [CNT_W-1:0] POOL_CNT = CNT_W'(POOL_SLOTS);

    // Request stage registers.
    logic                r_v;
    logic [KIND_W-1:0]   r_kind;
    logic [IDX_W-1:0]    r_idx;
    logic [GEN_W-1:0]    r_hgen;
    logic [SLOT_W-1:0]   r_slot;

    // Pool state held here; the free stack keeps its own count.
    logic [CNT_W-1:0]    r_used;
    logic [CNT_W-1:0]    n_used;

    // Result registers.
    logic                r_done;
    logic [STATUS_W-1:0] r_status;
    logic [IDX_W-1:0]    r_out_index;
    logic [GEN_W-1:0]    r_out_gen;
    logic                r_handle_ok;
    logic [STATUS_W-1:0] n_status;
    logic [IDX_W-1:0]    n_out_index;
    logic [GEN_W-1:0]    n_out_gen;
    logic                n_handle_ok;

    // Free stack view.
    logic [CNT_W-1:0]    w_fc;
    logic [CNT_W-1:0]    n_fc;
    logic [SLOT_W-1:0]   n_top;

    logic                w_accept;
    logic [ARITH_W-1:0]  w_idx_ext;
    logic [SLOT_W-1:0]   w_idx_addr;
    logic [SLOT_W-1:0]   w_alloc_addr;
    logic [SLOT_W-1:0]   w_rd_addr;
    logic [GEN_W-1:0]    w_gen_rd;
    logic [GEN_W-1:0]    w_gen_cur;
    logic [GEN_W-1:0]    w_new_gen;
    logic [ARITH_W-1:0]  w_slot_ext;
    logic                w_is_alloc;
    logic                w_is_free;
    logic                w_from_stack;
    logic                w_fresh;
    logic                w_match;
    logic                w_free_ok;
    logic                w_alloc_ok;
    logic                w_we;
    logic                w_push;
    logic                w_pop;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // ---------------------------------------------------------------------------------
    // Transfer cycle: choose the generation table address. For an allocate the slot is
    // the stack top or the next never-used slot, both as they stand once the request
    // now in the decision stage has been applied.
    // ---------------------------------------------------------------------------------
    assign w_idx_ext    = ARITH_W'(i_slot_index);
    assign w_idx_addr   = w_idx_ext[SLOT_W-1:0];
    assign w_alloc_addr = (n_fc != '0) ? n_top : n_used[SLOT_W-1:0];
    assign w_rd_addr    = (i_kind == KIND_ALLOC) ? w_alloc_addr : w_idx_addr;

    always_ff @(posedge i_clk) begin
        r_kind <= i_kind;
        r_idx  <= i_slot_index;
        r_hgen <= i_handle_generation;
        r_slot <= w_rd_addr;
    end

    // ---------------------------------------------------------------------------------
    // Decision stage: the stored generation is now at hand. A freshly taken slot has
    // generation zero whatever the table holds there.
    // ---------------------------------------------------------------------------------
    assign w_is_alloc   = (r_kind == KIND_ALLOC);
    assign w_is_free    = (r_kind == KIND_FREE);
    assign w_from_stack = (w_fc != '0);
    assign w_fresh      = !w_from_stack && (r_used < POOL_CNT);

    assign w_gen_cur = (w_is_alloc && w_fresh) ? '0 : w_gen_rd;
    assign w_new_gen = w_gen_cur + GEN_W'(1);

    // A handle is live when its index lies below the used-slot count and its generation
    // equals the stored one.
    assign w_match = (ARITH_W'(r_idx) < ARITH_W'(r_used)) && (w_gen_cur == r_hgen);

    // A free is refused when the stack is already full, which only a guessed handle
    // of a slot that is already on the stack can bring about.
    assign w_free_ok  = w_is_free && w_match && (w_fc < POOL_CNT);
    assign w_alloc_ok = w_is_alloc && (w_from_stack || w_fresh);

    assign w_we   = r_v && (w_alloc_ok || w_free_ok);
    assign w_push = r_v && w_free_ok;
    assign w_pop  = r_v && w_is_alloc && w_from_stack;
    assign n_used = (r_v && w_is_alloc && w_fresh) ? (r_used + CNT_W'(1)) : r_used;

    assign w_slot_ext = ARITH_W'(r_slot);

    always_comb begin
        n_status    = STATUS_BAD;
        n_out_index = '0;
        n_out_gen   = '0;
        n_handle_ok = 1'b0;
        case (r_kind)
            KIND_ALLOC: begin
                if (w_alloc_ok) begin
                    n_status    = STATUS_OK;
                    n_out_index = w_slot_ext[IDX_W-1:0];
                    n_out_gen   = w_new_gen;
                end else begin
                    n_status = STATUS_FULL;
                end
            end
            KIND_FREE: begin
                if (w_free_ok) begin
                    n_status    = STATUS_OK;
                    n_handle_ok = 1'b1;
                end
            end
            KIND_VALIDATE: begin
                if (w_match) begin
                    n_status    = STATUS_OK;
                    n_handle_ok = 1'b1;
                end
            end
            default: begin
                n_status = STATUS_BAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= 1'b0;
            r_used <= '0;
            r_done <= 1'b0;
        end else begin
            r_v    <= w_accept;
            r_used <= n_used;
            r_done <= r_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status    <= n_status;
        r_out_index <= n_out_index;
        r_out_gen   <= n_out_gen;
        r_handle_ok <= n_handle_ok;
    end

    gsa_gen_table #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_gen_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (w_rd_addr),
        .i_we      (w_we),
        .i_wr_addr (r_slot),
        .i_wr_data (w_new_gen),
        .o_rd_data (w_gen_rd)
    );

    gsa_free_stack #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_free_stack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_pop        (w_pop),
        .i_push_slot  (r_slot),
        .o_count      (w_fc),
        .o_next_count (n_fc),
        .o_next_top   (n_top)
    );

    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_out_index      = r_out_index;
    assign o_out_generation = r_out_gen;
    assign o_handle_ok      = r_handle_ok;

endmodule

FILE: hdl/gsa_checker.sv
// Port-level checks of the generational slot allocator, bound to the top level.
// Depends on gsa_pkg and generational_slot_allocator_macros.svh.
`include "generational_slot_allocator_macros.svh"

module gsa_checker
    import gsa_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_done,
    input logic [STATUS_W-1:0] o_status,
    input logic [IDX_W-1:0]    o_out_index,
    input logic [GEN_W-1:0]    o_out_generation,
    input logic                o_handle_ok
);

    // Every transfer yields exactly one result, through the request and result registers, unless reset intervened.
    `GSA_ASSERT_IMPL(a_one_result, i_clk, i_rst_n, 1'b1, o_done == ($past(start && !busy && i_rst_n, 2) && $past(i_rst_n)), "result strobe does not match accepted requests")

    // A matched handle is always reported with the ok status.
    `GSA_ASSERT_IMPL(a_ok_status, i_clk, i_rst_n, o_done && o_handle_ok, o_status == STATUS_OK, "handle_ok without ok status")

    // A refused request carries no handle and no match.
    `GSA_ASSERT_IMPL(a_fail_zero, i_clk, i_rst_n, o_done && (o_status != STATUS_OK), (o_out_index == '0) && (o_out_generation == '0) && !o_handle_ok, "refused request with nonzero result fields")

    // Right after a full pool the very next request cannot be a successful allocate.
    `GSA_ASSERT_NEXT(a_full_holds, i_clk, i_rst_n, o_done && (o_status == STATUS_FULL), !(o_done && (o_status == STATUS_OK) && !o_handle_ok), "allocate succeeded right after pool full")

endmodule

bind generational_slot_allocator gsa_checker u_gsa_checker (.*);

FILE: bench/generational_slot_allocator_tb.sv
// Self-checking testbench for the generational slot allocator: directed and random requests
// against a cycle-free model of the slot pool, generation table and LIFO free stack.
// Depends on gsa_pkg and generational_slot_allocator.
module generational_slot_allocator_tb;
    import gsa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Kind 3 has no operation behind it; the block must answer it as a bad request.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // Number of consecutive cycles without any transfer before the run is declared hung.
    // The longest correct quiet stretch is a sender gap, or the wait for a result plus the
    // closing wait, and both stay well below this limit.
    localparam int unsigned IDLE_LIMIT = 200;

    // Cycles to wait after the last expected result, to catch trailing strobes.
    localparam int unsigned TAIL_CYCLES = 8;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    index;
        logic [GEN_W-1:0]    generation;
        logic                ok;
    } t_slot_result;

    // The scoreboard keeps its own copy of the pool: per-slot generations, the free stack
    // with its depth, and the count of slots ever handed out. Each accepted request is
    // applied to that copy at once and the answer it must produce is queued.
    class t_slot_scoreboard;
        logic [GEN_W-1:0] gen_table [POOL_SLOTS_DEF];
        logic [IDX_W-1:0] free_stack [POOL_SLOTS_DEF];
        bit               live [POOL_SLOTS_DEF];
        int unsigned      free_depth;
        int unsigned      used_slots;
        t_slot_result     expected_q [$];
        int unsigned      mismatch_count;

        function new();
            foreach (gen_table[i]) begin
                gen_table[i]  = '0;
                free_stack[i] = '0;
                live[i]       = 1'b0;
            end
            free_depth     = 0;
            used_slots     = 0;
            mismatch_count = 0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function bit handle_current(logic [IDX_W-1:0] idx, logic [GEN_W-1:0] gen);
            return (int'(idx) < used_slots) && (gen_table[idx] == gen);
        endfunction

        // Returns a slot that is handed out and not yet freed, or -1 if there is none.
        function int pick_live_slot();
            int unsigned first;
            int unsigned slot;
            if (used_slots == 0) begin
                return -1;
            end
            first = $urandom_range(used_slots - 1);
            for (int unsigned n = 0; n < used_slots; n++) begin
                slot = (first + n) % used_slots;
                if (live[slot]) begin
                    return slot;
                end
            end
            return -1;
        endfunction

        function void note_request(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] idx,
                                   logic [GEN_W-1:0] gen);
            t_slot_result res;
            int unsigned  slot;
            res = '{status: STATUS_BAD, index: '0, generation: '0, ok: 1'b0};
            case (kind)
                KIND_ALLOC: begin
                    slot = POOL_SLOTS_DEF;
                    if (free_depth > 0) begin
                        free_depth--;
                        slot = free_stack[free_depth];
                    end else if (used_slots < POOL_SLOTS_DEF) begin
                        slot = used_slots;
                        used_slots++;
                    end
                    if (slot == POOL_SLOTS_DEF) begin
                        res.status = STATUS_FULL;
                    end else begin
                        gen_table[slot] = gen_table[slot] + GEN_W'(1);
                        live[slot]      = 1'b1;
                        res.status      = STATUS_OK;
                        res.index       = IDX_W'(slot);
                        res.generation  = gen_table[slot];
                    end
                end
                KIND_FREE: begin
                    // A matching handle is still refused when the stack has no room.
                    if (handle_current(idx, gen) && free_depth < POOL_SLOTS_DEF) begin
                        gen_table[idx]         = gen_table[idx] + GEN_W'(1);
                        free_stack[free_depth] = idx;
                        free_depth++;
                        live[idx]  = 1'b0;
                        res.status = STATUS_OK;
                        res.ok     = 1'b1;
                    end
                end
                KIND_VALIDATE: begin
                    if (handle_current(idx, gen)) begin
                        res.status = STATUS_OK;
                        res.ok     = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            expected_q.insert(expected_q.size(), res);
        endfunction

        task report_mismatch(string msg);
            mismatch_count++;
            $display("%0t ns: mismatch: %s", $realtime, msg);
        endtask

        task check_result(t_slot_result got);
            t_slot_result want;
            if (expected_q.size() == 0) begin
                report_mismatch("result strobe with no request outstanding");
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status) begin
                report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
            end
            if (got.index !== want.index) begin
                report_mismatch($sformatf("out_index %0d, expected %0d", got.index, want.index));
            end
            if (got.generation !== want.generation) begin
                report_mismatch($sformatf("out_generation %0h, expected %0h",
                                          got.generation, want.generation));
            end
            if (got.ok !== want.ok) begin
                report_mismatch($sformatf("handle_ok %0b, expected %0b", got.ok, want.ok));
            end
        endtask
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [KIND_W-1:0]   i_kind = KIND_ALLOC;
    logic [IDX_W-1:0]    i_slot_index = '0;
    logic [GEN_W-1:0]    i_handle_generation = '0;
    logic                o_done;
    logic [STATUS_W-1:0] o_status;
    logic [IDX_W-1:0]    o_out_index;
    logic [GEN_W-1:0]    o_out_generation;
    logic                o_handle_ok;

    t_slot_scoreboard sb = new();
    int unsigned      idle_cycles = 0;

    generational_slot_allocator dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_kind              (i_kind),
        .i_slot_index        (i_slot_index),
        .i_handle_generation (i_handle_generation),
        .o_done              (o_done),
        .o_status            (o_status),
        .o_out_index         (o_out_index),
        .o_out_generation    (o_out_generation),
        .o_handle_ok         (o_handle_ok)
    );

    always #4 i_clk = ~i_clk;

    // Results are sampled at the rising edge that closes their one valid cycle. The block
    // updates its outputs with nonblocking assignments, so the values read here are the ones
    // that stood during the cycle that just ended.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            sb.check_result('{status: o_status, index: o_out_index,
                              generation: o_out_generation, ok: o_handle_ok});
        end
    end

    // The watchdog counts cycles in which neither a request nor a result transfer takes place.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Drives one request from a falling edge and holds it until a rising edge transfers it.
    // A back-to-back request keeps start high, since the next assignment lands on the next
    // falling edge and never in the same time step as a lowering.
    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] idx,
                                input logic [GEN_W-1:0] gen);
        @(negedge i_clk);
        start               <= 1'b1;
        i_kind              <= kind;
        i_slot_index        <= idx;
        i_handle_generation <= gen;
        do begin
            @(posedge i_clk);
        end while (busy);
        sb.note_request(kind, idx, gen);
    endtask

    task automatic idle_gap(input int unsigned cycles);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Stops sending and waits until every outstanding result has been checked.
    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Allocate ignores the handle fields, so they carry noise.
    task automatic send_alloc();
        send_request(KIND_ALLOC, IDX_W'($urandom), $urandom);
    endtask

    // Free or validate with a handle that is mostly well formed: usually a live handle, at
    // times a current or one-behind generation of any used slot (which covers a repeated free
    // with a guessed generation), and otherwise an arbitrary index and generation.
    task automatic send_handle_request(input logic [KIND_W-1:0] kind);
        int unsigned      mode;
        int               slot;
        logic [IDX_W-1:0] idx;
        logic [GEN_W-1:0] gen;
        mode = $urandom_range(99);
        slot = sb.pick_live_slot();
        if (mode < 70 && slot >= 0) begin
            idx = IDX_W'(slot);
            gen = sb.gen_table[slot];
        end else if (mode < 85 && sb.used_slots > 0) begin
            idx = IDX_W'($urandom_range(sb.used_slots - 1));
            gen = sb.gen_table[idx] - GEN_W'($urandom_range(1));
        end else begin
            idx = IDX_W'($urandom);
            case ($urandom_range(3))
                0:       gen = '0;
                1:       gen = '1;
                default: gen = $urandom;
            endcase
        end
        send_request(kind, idx, gen);
    endtask

    // Mixed traffic. Allocates slightly outweigh frees so that the used range keeps growing.
    task automatic run_mixed(input int unsigned count, input bit with_gaps);
        int unsigned pick;
        for (int unsigned n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 42) begin
                send_alloc();
            end else if (pick < 77) begin
                send_handle_request(KIND_FREE);
            end else if (pick < 95) begin
                send_handle_request(KIND_VALIDATE);
            end else begin
                send_request(KIND_UNUSED, IDX_W'($urandom), $urandom);
            end
            if (with_gaps && $urandom_range(3) == 0) begin
                idle_gap($urandom_range(1, 6));
            end
            if (with_gaps && (n % 200) == 199) begin
                drain_results();
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening on a fresh pool.
        send_request(KIND_ALLOC, '0, '0);              // fresh slot 0, generation 1
        send_request(KIND_VALIDATE, 10'd0, 32'd1);     // live handle
        send_request(KIND_VALIDATE, 10'd0, 32'd0);     // stale generation
        send_request(KIND_VALIDATE, 10'd1, 32'd0);     // index beyond the used range
        send_request(KIND_VALIDATE, '1, '1);           // highest index and generation
        send_request(KIND_FREE, 10'd0, 32'd0);         // stale handle refused
        send_request(KIND_FREE, '1, 32'd0);            // out-of-range handle refused
        send_request(KIND_FREE, 10'd0, 32'd1);         // good free, slot goes on the stack
        send_request(KIND_VALIDATE, 10'd0, 32'd1);     // now stale
        send_request(KIND_FREE, 10'd0, 32'd2);         // repeated free with a guessed generation
        send_request(KIND_ALLOC, '0, '0);              // pops slot 0
        send_request(KIND_ALLOC, '1, '1);              // pops slot 0 again
        send_request(KIND_ALLOC, '0, '1);              // stack empty, fresh slot 1
        send_request(KIND_UNUSED, '1, '1);
        send_request(KIND_UNUSED, '0, '0);
        send_request(KIND_VALIDATE, 10'd1, 32'd1);
        send_request(KIND_FREE, 10'd1, '1);            // wrong generation
        send_request(KIND_FREE, 10'd0, 32'd5);         // live handle of slot 0
        send_request(KIND_ALLOC, '1, '1);
        drain_results();

        run_mixed(680, 1'b1);
        drain_results();

        // Closing stretch with the sender never pausing.
        run_mixed(150, 1'b0);

        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.mismatch_count == 0 && sb.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

FILE: sim.f
+incdir+hdl
hdl/gsa_pkg.sv
hdl/gsa_gen_table.sv
hdl/gsa_free_stack.sv
hdl/generational_slot_allocator.sv
hdl/gsa_checker.sv
bench/generational_slot_allocator_tb.sv
